// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the RTL of the line parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define GFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define GFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/gfa_lsp_pkg.sv
// ----------------------------------------------------------------------------
// gfa_lsp_pkg
// Shared widths, character codes and record types of the GFA line parser.
// ----------------------------------------------------------------------------
package gfa_lsp_pkg;

  // id and length widths
  localparam int unsigned ID_BITS  = 31;
  localparam int unsigned LEN_BITS = 32;

  localparam logic [ID_BITS-1:0]  ID_MAX  = '1;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // record kinds
  typedef enum logic [1:0] {
    KIND_SEGMENT = 2'd0,
    KIND_PATH    = 2'd1,
    KIND_WALK    = 2'd2
  } kind_e;

  // one result word
  typedef struct packed {
    kind_e               kind;
    logic [ID_BITS-1:0]  id;
    logic                fwd;
    logic [LEN_BITS-1:0] len;
    logic                last;
    logic                sat;
  } rec_t;

endpackage

// File: rtl/core/gfa_lsp_byte_if.sv
// ----------------------------------------------------------------------------
// gfa_lsp_byte_if
// Valid/ready channel carrying one text byte per word.
// ----------------------------------------------------------------------------
interface gfa_lsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// File: rtl/core/gfa_lsp_rec_if.sv
// ----------------------------------------------------------------------------
// gfa_lsp_rec_if
// Valid/ready channel carrying one parsed record per word.
// ----------------------------------------------------------------------------
interface gfa_lsp_rec_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       record_kind;
  logic [gfa_lsp_pkg::ID_BITS-1:0]  segment_id;
  logic                             forward;
  logic [gfa_lsp_pkg::LEN_BITS-1:0] seq_length;
  logic                             last_in_line;
  logic                             id_saturated;

  modport source (
    output valid, output record_kind, output segment_id, output forward,
    output seq_length, output last_in_line, output id_saturated, input ready
  );
  modport sink (
    input valid, input record_kind, input segment_id, input forward,
    input seq_length, input last_in_line, input id_saturated, output ready
  );
endinterface

// File: rtl/core/gfa_lsp_in_reg.sv
// ----------------------------------------------------------------------------
// gfa_lsp_in_reg
// Input register: holds one text byte until the parser step consumes it.
// ----------------------------------------------------------------------------
module gfa_lsp_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  gfa_lsp_byte_if.sink        text_i,
  input  logic                advance_i,
  output logic                valid_o,
  output logic [7:0]          byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  // free when empty or when the held byte moves on this cycle
  assign text_i.ready = !valid_q || advance_i;
  assign take         = text_i.valid && text_i.ready;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = text_i.text_byte;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: rtl/core/gfa_lsp_core.sv
// ----------------------------------------------------------------------------
// gfa_lsp_core
// Line state and one-byte parse step: line type, field tracking, id digits
// and sequence length; flags a record when one is due.
// ----------------------------------------------------------------------------
module gfa_lsp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              emit_o,
  output gfa_lsp_pkg::rec_t rec_o
);

  typedef enum logic [1:0] {
    LT_OTHER = 2'd0,
    LT_SEG   = 2'd1,
    LT_PATH  = 2'd2,
    LT_WALK  = 2'd3
  } line_e;

  typedef enum logic [1:0] {
    COL_START = 2'd0,
    COL_SKIP  = 2'd1,
    COL_EMPTY = 2'd2,
    COL_OPEN  = 2'd3
  } col_e;

  localparam logic [2:0] FIELD_SEQ  = 3'd1;
  localparam logic [2:0] FIELD_LIST = 3'd1;
  localparam logic [2:0] FIELD_WALK = 3'd5;
  localparam int unsigned PW = gfa_lsp_pkg::ID_BITS + 4;

  line_e                            line_q, line_d;
  col_e                             col_q, col_d;
  logic [2:0]                       field_q, field_d;
  logic [gfa_lsp_pkg::ID_BITS-1:0]  acc_q, acc_d;
  logic                             ended_q, ended_d;
  logic                             ov_q, ov_d;
  logic                             strand_q, strand_d;
  logic [7:0]                       prev_q, prev_d;
  logic [gfa_lsp_pkg::LEN_BITS-1:0] len_q, len_d;
  logic                             fin_q, fin_d;

  // shared digit unit
  logic                            feed_en, clr;
  logic [7:0]                      feed_byte;
  logic                            is_dig;
  logic [3:0]                      dig;
  logic [PW-1:0]                   prod;
  logic                            prod_sat;
  logic [gfa_lsp_pkg::ID_BITS-1:0] feed_acc;
  logic                            feed_ended, feed_ov;
  logic                            is_tab, is_sep, is_arrow;

  assign is_dig   = (feed_byte >= gfa_lsp_pkg::CH_ZERO) && (feed_byte <= gfa_lsp_pkg::CH_NINE);
  assign dig      = 4'(feed_byte - gfa_lsp_pkg::CH_ZERO);
  // acc * 10 + digit, wide enough to never wrap
  assign prod     = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0}) + PW'(dig);
  assign prod_sat = prod > PW'(gfa_lsp_pkg::ID_MAX);

  always_comb begin
    feed_acc   = acc_q;
    feed_ended = ended_q;
    feed_ov    = ov_q;
    if (!ended_q) begin
      if (!is_dig) begin
        feed_ended = 1'b1;
      end else if (prod_sat) begin
        feed_acc = gfa_lsp_pkg::ID_MAX;
        feed_ov  = 1'b1;
      end else begin
        feed_acc = prod[gfa_lsp_pkg::ID_BITS-1:0];
      end
    end
  end

  assign is_tab   = byte_i == gfa_lsp_pkg::CH_TAB;
  assign is_sep   = is_tab || (byte_i == gfa_lsp_pkg::CH_COMMA);
  assign is_arrow = (byte_i == gfa_lsp_pkg::CH_GT) || (byte_i == gfa_lsp_pkg::CH_LT);
  assign feed_byte = (line_q == LT_PATH) ? prev_q : byte_i;

  // parse step
  always_comb begin
    line_d   = line_q;
    col_d    = col_q;
    field_d  = field_q;
    strand_d = strand_q;
    prev_d   = prev_q;
    len_d    = len_q;
    fin_d    = fin_q;
    feed_en  = 1'b0;
    clr      = 1'b0;
    emit_o   = 1'b0;
    rec_o.kind = gfa_lsp_pkg::KIND_SEGMENT;
    rec_o.id   = acc_q;
    rec_o.fwd  = 1'b0;
    rec_o.len  = '0;
    rec_o.last = 1'b0;
    rec_o.sat  = ov_q;

    if (byte_i == gfa_lsp_pkg::CH_LF) begin
      // end of line: flush pending record and start over
      rec_o.last = 1'b1;
      unique case (line_q)
        LT_SEG: begin
          emit_o    = 1'b1;
          rec_o.len = len_q;
        end
        LT_PATH: begin
          emit_o     = (field_q == FIELD_LIST) && !fin_q;
          rec_o.kind = gfa_lsp_pkg::KIND_PATH;
          rec_o.fwd  = (col_q == COL_OPEN) && (prev_q == gfa_lsp_pkg::CH_PLUS);
        end
        LT_WALK: begin
          emit_o     = (field_q == FIELD_WALK) && !fin_q;
          rec_o.kind = gfa_lsp_pkg::KIND_WALK;
          if (col_q == COL_OPEN) begin
            rec_o.fwd = strand_q;
          end else begin
            rec_o.id = '0;
          end
        end
        default: begin
          emit_o = 1'b0;
        end
      endcase
      line_d   = LT_OTHER;
      col_d    = COL_START;
      field_d  = '0;
      fin_d    = 1'b0;
      strand_d = 1'b0;
      prev_d   = '0;
      len_d    = '0;
      clr      = 1'b1;
    end else if (col_q == COL_START) begin
      // first byte gives the line type
      priority if (byte_i == gfa_lsp_pkg::CH_S) begin
        line_d = LT_SEG;
      end else if (byte_i == gfa_lsp_pkg::CH_P) begin
        line_d = LT_PATH;
      end else if (byte_i == gfa_lsp_pkg::CH_W) begin
        line_d = LT_WALK;
      end else begin
        line_d = LT_OTHER;
      end
      col_d = COL_SKIP;
    end else if (col_q == COL_SKIP) begin
      col_d = COL_EMPTY;
    end else begin
      unique case (line_q)
        LT_SEG: begin
          if (field_q == '0) begin
            if (is_tab) field_d = FIELD_SEQ;
            else        feed_en = 1'b1;
          end else if (field_q == FIELD_SEQ) begin
            if (is_tab) begin
              field_d = FIELD_SEQ + 3'd1;
            end else if (len_q != gfa_lsp_pkg::LEN_MAX) begin
              len_d = len_q + gfa_lsp_pkg::LEN_BITS'(1);
            end
          end
        end
        LT_PATH: begin
          if (!fin_q) begin
            if (field_q == '0) begin
              if (is_tab) begin
                field_d = FIELD_LIST;
                col_d   = COL_EMPTY;
                clr     = 1'b1;
              end
            end else if (is_sep) begin
              // element closed: its last char is the orientation
              emit_o     = 1'b1;
              rec_o.kind = gfa_lsp_pkg::KIND_PATH;
              rec_o.fwd  = (col_q == COL_OPEN) && (prev_q == gfa_lsp_pkg::CH_PLUS);
              rec_o.last = is_tab;
              fin_d      = fin_q || is_tab;
              col_d      = COL_EMPTY;
              clr        = 1'b1;
            end else begin
              feed_en = col_q == COL_OPEN;
              prev_d  = byte_i;
              col_d   = COL_OPEN;
            end
          end
        end
        LT_WALK: begin
          if (!fin_q) begin
            if (field_q < FIELD_WALK) begin
              if (is_tab) begin
                field_d = field_q + 3'd1;
                col_d   = COL_EMPTY;
                clr     = 1'b1;
              end
            end else if (col_q == COL_EMPTY) begin
              if (is_tab) begin
                // empty walk gives one null step
                emit_o     = 1'b1;
                rec_o.kind = gfa_lsp_pkg::KIND_WALK;
                rec_o.id   = '0;
                rec_o.last = 1'b1;
                fin_d      = 1'b1;
              end else begin
                strand_d = byte_i == gfa_lsp_pkg::CH_GT;
                col_d    = COL_OPEN;
                clr      = 1'b1;
              end
            end else if (is_tab) begin
              emit_o     = 1'b1;
              rec_o.kind = gfa_lsp_pkg::KIND_WALK;
              rec_o.fwd  = strand_q;
              rec_o.last = 1'b1;
              fin_d      = 1'b1;
            end else if (is_arrow) begin
              emit_o     = 1'b1;
              rec_o.kind = gfa_lsp_pkg::KIND_WALK;
              rec_o.fwd  = strand_q;
              strand_d   = byte_i == gfa_lsp_pkg::CH_GT;
              clr        = 1'b1;
            end else begin
              feed_en = 1'b1;
            end
          end
        end
        default: begin
          line_d = line_q;
        end
      endcase
    end

    // id accumulator update
    if (clr) begin
      acc_d   = '0;
      ended_d = 1'b0;
      ov_d    = 1'b0;
    end else if (feed_en) begin
      acc_d   = feed_acc;
      ended_d = feed_ended;
      ov_d    = feed_ov;
    end else begin
      acc_d   = acc_q;
      ended_d = ended_q;
      ov_d    = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= LT_OTHER;
      col_q    <= COL_START;
      field_q  <= '0;
      acc_q    <= '0;
      ended_q  <= 1'b0;
      ov_q     <= 1'b0;
      strand_q <= 1'b0;
      prev_q   <= '0;
      len_q    <= '0;
      fin_q    <= 1'b0;
    end else if (step_i) begin
      line_q   <= line_d;
      col_q    <= col_d;
      field_q  <= field_d;
      acc_q    <= acc_d;
      ended_q  <= ended_d;
      ov_q     <= ov_d;
      strand_q <= strand_d;
      prev_q   <= prev_d;
      len_q    <= len_d;
      fin_q    <= fin_d;
    end
  end

endmodule

// File: rtl/core/gfa_lsp_out_reg.sv
// ----------------------------------------------------------------------------
// gfa_lsp_out_reg
// Result register: holds one record until the downstream side takes it.
// ----------------------------------------------------------------------------
module gfa_lsp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              emit_i,
  input  gfa_lsp_pkg::rec_t rec_i,
  output logic              free_o,
  gfa_lsp_rec_if.source     rec_o
);

  logic              valid_q, valid_d;
  gfa_lsp_pkg::rec_t rec_q, rec_d;

  // room for a new word when empty or draining now
  assign free_o = !valid_q || rec_o.ready;

  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (load_i) begin
      valid_d = emit_i;
      rec_d   = rec_i;
    end else if (rec_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o.valid        = valid_q;
  assign rec_o.record_kind  = rec_q.kind;
  assign rec_o.segment_id   = rec_q.id;
  assign rec_o.forward      = rec_q.fwd;
  assign rec_o.seq_length   = rec_q.len;
  assign rec_o.last_in_line = rec_q.last;
  assign rec_o.id_saturated = rec_q.sat;

endmodule

// File: rtl/core/gfa_line_stream_parser.sv
// Path of a record: the byte causing it is accepted into the input register, then the
// parse step writes the record into the result register, which drives rec_o.
// Throughput: one byte per cycle; the parse step advances whenever the result
// register is empty or being drained, so a stalled rec_o holds back text_i.
// Reset (rst_ni low, asynchronous): both registers empty, line state at line start.
// ----------------------------------------------------------------------------
// gfa_line_stream_parser
// GFA text parser: bytes in, segment / path step / walk step records out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfa_line_stream_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  gfa_lsp_byte_if.sink  text_i,
  gfa_lsp_rec_if.source rec_o
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_free;
  logic              advance;
  logic              emit;
  gfa_lsp_pkg::rec_t rec;

  // parse step runs when a byte is held and the result slot is free
  assign advance = in_valid && out_free;

  gfa_lsp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .text_i    (text_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  gfa_lsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte),
    .emit_o (emit),
    .rec_o  (rec)
  );

  gfa_lsp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .emit_i (emit),
    .rec_i  (rec),
    .free_o (out_free),
    .rec_o  (rec_o)
  );

  // checks
  `GFA_ASSERT(a_accept_fills_in_reg, text_i.valid && text_i.ready |=> in_valid, "accepted byte lost")
  `GFA_ASSERT(a_step_len_zero, rec_o.valid && rec_o.record_kind != gfa_lsp_pkg::KIND_SEGMENT |-> rec_o.seq_length == '0, "step record with length")
  `GFA_ASSERT(a_seg_is_last, rec_o.valid && rec_o.record_kind == gfa_lsp_pkg::KIND_SEGMENT |-> rec_o.last_in_line, "segment record not last")
  `GFA_ASSERT(a_sat_is_max, rec_o.valid && rec_o.id_saturated |-> rec_o.segment_id == gfa_lsp_pkg::ID_MAX, "saturated id not clamped")
  `GFA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !rec_o.valid && !in_valid, "registers not empty in reset")

endmodule
